// ----- hdl/jbrs_pkg.sv -----
// Shared types, constants and helper functions for the JPEG run-length symbolizer.
package jbrs_pkg;

   // Field widths
   localparam int COEF_W     = 12;
   localparam int DIFF_W     = 13;
   localparam int AMP_W      = 12;
   localparam int SIZE_W     = 4;
   localparam int COMP_W     = 2;
   localparam int SYM_W      = 8;
   localparam int ZERO_RUN_W = 6;
   localparam int ZRL_CNT_W  = 2;

   // Default configuration
   localparam int BLOCK_COEFFS_DEFAULT = 64;
   localparam int QUEUE_DEPTH_DEFAULT  = 4;

   // Special AC symbols
   localparam logic [SYM_W-1:0] SYM_ZRL = 8'hF0;
   localparam logic [SYM_W-1:0] SYM_EOB = 8'h00;

   // One request: a single coefficient of the block
   typedef struct packed {
      logic signed [COEF_W-1:0] coefficient;
      logic signed [COEF_W-1:0] previous_dc;
      logic [COMP_W-1:0]        component;
   } req_type;

   // One result symbol
   typedef struct packed {
      logic [SYM_W-1:0]  symbol;
      logic              is_ac;
      logic [AMP_W-1:0]  amplitude_bits;
      logic [SIZE_W-1:0] amplitude_length;
      logic [COMP_W-1:0] component_out;
      logic              last_of_item;
      logic              block_end;
   } rsp_type;

   // Command from front to back: leading run-sixteen count plus the final symbol
   typedef struct packed {
      logic [ZRL_CNT_W-1:0] zrl_count;
      logic [SYM_W-1:0]     symbol;
      logic                 is_ac;
      logic [AMP_W-1:0]     amplitude_bits;
      logic [SIZE_W-1:0]    amplitude_length;
      logic [COMP_W-1:0]    component;
      logic                 block_end;
   } cmd_type;

   // Front-to-queue write port
   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } push_type;

   // Bit length of a magnitude (size category)
   function automatic logic [SIZE_W-1:0] size_category(input logic [DIFF_W-1:0] mag);
      logic [SIZE_W-1:0] size;
      size = '0;
      for (int i = 0; i < DIFF_W; i++) begin
         if (mag[i]) size = SIZE_W'(i + 1);
      end
      return size;
   endfunction

   // Amplitude bits: value itself, or value - 1 in the low size bits when negative
   function automatic logic [AMP_W-1:0] amplitude(input logic [DIFF_W-1:0] value,
                                                   input logic [SIZE_W-1:0] size);
      logic [DIFF_W-1:0] adj;
      logic [AMP_W-1:0]  mask;
      adj  = value[DIFF_W-1] ? value - DIFF_W'(1) : value;
      mask = ~({AMP_W{1'b1}} << size);
      return adj[AMP_W-1:0] & mask;
   endfunction

endpackage

// ----- hdl/jpeg_block_run_length_symbolizer_core.sv -----
// JPEG block run-length symbolizer: takes one quantized coefficient per request, in block
// order with DC first, and returns JPEG baseline symbols (DC size, AC run/size, run sixteen,
// end of block) with their amplitude bits, ready for Huffman lookup. A request is taken
// every cycle while the command queue (QUEUE_DEPTH entries) has room; the front end
// classifies it in the same cycle; its command passes through the queue, then the output
// register. Zero AC coefficients before the end of a block give no result. A nonzero AC
// coefficient after a run of 16*k or more zeros gives k extra run-sixteen results (k up to
// 3), and the output side emits one result per cycle while not stalled, so such a request
// gives k + 1 results in turn; the queue absorbs these bursts while requests keep flowing.
// No clearing pass is needed after reset.
module jpeg_block_run_length_symbolizer_core #(
   parameter int BLOCK_COEFFS = jbrs_pkg::BLOCK_COEFFS_DEFAULT,
   parameter int QUEUE_DEPTH  = jbrs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  jbrs_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output jbrs_pkg::rsp_type rsp_payload
);

   jbrs_pkg::push_type queue_wr;
   jbrs_pkg::cmd_type  head;
   logic               queue_full, head_valid, pop;

   // Request classification
   jbrs_front #(
      .BLOCK_COEFFS (BLOCK_COEFFS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .queue_wr    (queue_wr)
   );

   // Command queue
   jbrs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .wr         (queue_wr),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // Symbol emission
   jbrs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- hdl/jbrs_front.sv -----
// Front end: accepts coefficients, tracks block position and zero run, builds commands.
module jbrs_front #(
   parameter int BLOCK_COEFFS = jbrs_pkg::BLOCK_COEFFS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  jbrs_pkg::req_type  req_payload,
   input  logic               queue_full,
   output jbrs_pkg::push_type queue_wr
);

   localparam int POS_W = (BLOCK_COEFFS > 1) ? $clog2(BLOCK_COEFFS) : 1;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_COEFFS - 1);

   logic [POS_W-1:0]                position_ff, position_in;
   logic [jbrs_pkg::ZERO_RUN_W-1:0] zero_run_ff, zero_run_in;

   logic                            accept;
   logic                            is_dc, is_last, is_zero;
   logic [jbrs_pkg::DIFF_W-1:0]     coef_ext, prev_ext, diff, value, mag;
   logic [jbrs_pkg::SIZE_W-1:0]     size;
   logic [jbrs_pkg::AMP_W-1:0]      amp;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Classify the coefficient
   assign is_dc   = (position_ff == '0);
   assign is_last = (position_ff == LAST_POS);
   assign is_zero = (req_payload.coefficient == '0);

   // Size category and amplitude of the DC difference or AC value
   assign coef_ext = {req_payload.coefficient[jbrs_pkg::COEF_W-1], req_payload.coefficient};
   assign prev_ext = {req_payload.previous_dc[jbrs_pkg::COEF_W-1], req_payload.previous_dc};
   assign diff     = coef_ext - prev_ext;
   assign value    = is_dc ? diff : coef_ext;
   assign mag      = value[jbrs_pkg::DIFF_W-1] ? (~value + jbrs_pkg::DIFF_W'(1)) : value;
   assign size     = jbrs_pkg::size_category(mag);
   assign amp      = jbrs_pkg::amplitude(value, size);

   // Command build
   always_comb begin
      queue_wr.push                 = 1'b0;
      queue_wr.cmd.zrl_count        = '0;
      queue_wr.cmd.symbol           = {{(jbrs_pkg::SYM_W - jbrs_pkg::SIZE_W){1'b0}}, size};
      queue_wr.cmd.is_ac            = 1'b0;
      queue_wr.cmd.amplitude_bits   = amp;
      queue_wr.cmd.amplitude_length = size;
      queue_wr.cmd.component        = req_payload.component;
      queue_wr.cmd.block_end        = is_last;
      if (is_dc) begin
         queue_wr.push = accept;
      end else if (is_zero) begin
         // zero AC: only the end-of-block symbol at the last position
         queue_wr.push                 = accept && is_last;
         queue_wr.cmd.symbol           = jbrs_pkg::SYM_EOB;
         queue_wr.cmd.is_ac            = 1'b1;
         queue_wr.cmd.amplitude_bits   = '0;
         queue_wr.cmd.amplitude_length = '0;
      end else begin
         queue_wr.push          = accept;
         queue_wr.cmd.zrl_count = zero_run_ff[jbrs_pkg::ZERO_RUN_W-1 -: jbrs_pkg::ZRL_CNT_W];
         queue_wr.cmd.symbol    = {zero_run_ff[3:0], size};
         queue_wr.cmd.is_ac     = 1'b1;
      end
   end

   // Position and zero run update
   always_comb begin
      position_in = position_ff;
      zero_run_in = zero_run_ff;
      if (accept) begin
         if (is_last) begin
            position_in = '0;
            zero_run_in = '0;
         end else begin
            position_in = position_ff + POS_W'(1);
            if (!is_dc && is_zero) zero_run_in = zero_run_ff + jbrs_pkg::ZERO_RUN_W'(1);
            else                   zero_run_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         zero_run_ff <= '0;
      end else begin
         position_ff <= position_in;
         zero_run_ff <= zero_run_in;
      end
   end

endmodule

// ----- hdl/jbrs_queue.sv -----
// Short command queue between the front end and the symbol emitter.
module jbrs_queue #(
   parameter int DEPTH = jbrs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  jbrs_pkg::push_type wr,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output jbrs_pkg::cmd_type  head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

   jbrs_pkg::cmd_type entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr.push) wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (wr.push && !do_pop)      count_in = count_ff + CNT_W'(1);
      else if (!wr.push && do_pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (wr.push) entries_ff[wr_ptr_ff] <= wr.cmd;
   end

endmodule

// ----- hdl/jbrs_back.sv -----
// Back end: expands each command into run-sixteen symbols and its final symbol.
module jbrs_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  jbrs_pkg::cmd_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output jbrs_pkg::rsp_type rsp_payload
);

   logic [jbrs_pkg::ZRL_CNT_W-1:0] zrl_done_ff, zrl_done_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   jbrs_pkg::rsp_type              rsp_payload_ff, rsp_payload_in;
   logic                           out_free, load, emit_zrl;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = out_free && head_valid;
   assign emit_zrl = (zrl_done_ff != head.zrl_count);
   assign pop      = load && !emit_zrl;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Next result: a run-sixteen symbol while any are owed, then the final symbol
   always_comb begin
      rsp_payload_in.symbol           = head.symbol;
      rsp_payload_in.is_ac            = head.is_ac;
      rsp_payload_in.amplitude_bits   = head.amplitude_bits;
      rsp_payload_in.amplitude_length = head.amplitude_length;
      rsp_payload_in.component_out    = head.component;
      rsp_payload_in.last_of_item     = 1'b1;
      rsp_payload_in.block_end        = head.block_end;
      zrl_done_in                     = zrl_done_ff;
      if (emit_zrl) begin
         rsp_payload_in.symbol           = jbrs_pkg::SYM_ZRL;
         rsp_payload_in.is_ac            = 1'b1;
         rsp_payload_in.amplitude_bits   = '0;
         rsp_payload_in.amplitude_length = '0;
         rsp_payload_in.last_of_item     = 1'b0;
      end
      if (load) begin
         if (emit_zrl) zrl_done_in = zrl_done_ff + jbrs_pkg::ZRL_CNT_W'(1);
         else          zrl_done_in = '0;
      end
   end

   // Output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load)          rsp_valid_in = 1'b1;
      else if (out_free) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         zrl_done_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         zrl_done_ff  <= zrl_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) rsp_payload_ff <= rsp_payload_in;
   end

endmodule

// ----- hdl/jbrs_checker.sv -----
// Port-level checks for the run-length symbolizer, bound to the top level.
module jbrs_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input jbrs_pkg::rsp_type rsp_payload
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // Nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // DC symbol is the size category itself
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.is_ac |->
         rsp_payload.symbol[7:4] == 4'd0 &&
         rsp_payload.symbol[3:0] == rsp_payload.amplitude_length)
      else $error("DC symbol does not match amplitude length");

   // Run-sixteen never ends an item and carries no amplitude
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.is_ac && rsp_payload.symbol == jbrs_pkg::SYM_ZRL |->
         !rsp_payload.last_of_item && rsp_payload.amplitude_length == 4'd0 &&
         rsp_payload.amplitude_bits == 12'd0)
      else $error("bad run-sixteen result");

   // Zero-length amplitude has no bits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.amplitude_length == 4'd0 |->
         rsp_payload.amplitude_bits == 12'd0)
      else $error("amplitude bits without length");

endmodule

bind jpeg_block_run_length_symbolizer_core jbrs_checker u_checker (.*);

// ----- bench/jpeg_block_run_length_symbolizer_core_tb.sv -----
// Self-checking testbench for the JPEG block run-length symbolizer core.
`timescale 1ns / 100ps

module jpeg_block_run_length_symbolizer_core_tb;

   localparam int COEFFS_PER_BLOCK = jbrs_pkg::BLOCK_COEFFS_DEFAULT;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int IDLE_PCT         = 29;
   localparam int CALM_FIRST       = 300;
   localparam int CALM_LAST        = 420;
   localparam int RANDOM_BLOCKS    = 3;

   // queued request plus a flag to hold it back until all symbols have drained
   typedef struct packed {
      logic              drain;
      jbrs_pkg::req_type req;
   } pending_request_type;

   logic              clock;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   jbrs_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   jbrs_pkg::rsp_type rsp_payload;

   pending_request_type request_queue[$];
   jbrs_pkg::rsp_type   expected_symbols[$];
   pending_request_type head;
   jbrs_pkg::rsp_type   want;
   int                  coef_plan[COEFFS_PER_BLOCK];
   int                  coef_index        = 0;
   int                  zero_count        = 0;
   int                  requests_accepted = 0;
   int                  mismatch_count    = 0;
   int                  cycle_count       = 0;
   bit                  req_taken         = 1'b0;
   bit                  calm;

   jpeg_block_run_length_symbolizer_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // size category: bit length of the magnitude
   function automatic int bit_length(input int v);
      int mag;
      int n;
      mag = (v < 0) ? -v : v;
      n   = 0;
      while ((mag >> n) != 0) n++;
      return n;
   endfunction

   // negative values carry value + 2^size - 1 in the low bits
   function automatic logic [11:0] amplitude_code(input int v, input int sz);
      int a;
      a = v;
      if (v < 0) a = v + (1 << sz) - 1;
      return a[11:0];
   endfunction

   function automatic jbrs_pkg::rsp_type make_symbol(input logic [7:0] sym, input logic ac,
                                                     input logic [11:0] bits, input int len,
                                                     input logic [1:0] comp,
                                                     input logic blk_end);
      jbrs_pkg::rsp_type s;
      s.symbol           = sym;
      s.is_ac            = ac;
      s.amplitude_bits   = bits;
      s.amplitude_length = len[3:0];
      s.component_out    = comp;
      s.last_of_item     = 1'b0;
      s.block_end        = blk_end;
      return s;
   endfunction

   // work out the symbols one coefficient produces and queue them
   task automatic symbolize_coefficient(input jbrs_pkg::req_type r);
      int                coef;
      int                diff;
      int                sz;
      int                n;
      int                k;
      bit                at_end;
      jbrs_pkg::rsp_type burst[4];
      coef   = $signed(r.coefficient);
      at_end = (coef_index >= COEFFS_PER_BLOCK - 1);
      n      = 0;
      if (coef_index == 0) begin
         diff     = coef - $signed(r.previous_dc);
         sz       = bit_length(diff);
         burst[0] = make_symbol(8'(sz), 1'b0, amplitude_code(diff, sz), sz,
                                r.component, at_end);
         n          = 1;
         zero_count = 0;
      end else if (coef == 0) begin
         zero_count = (zero_count + 1) & 63;
         // trailing zeros collapse into end of block, no run-sixteen symbols
         if (at_end) begin
            burst[0] = make_symbol(jbrs_pkg::SYM_EOB, 1'b1, 12'd0, 0, r.component, 1'b1);
            n        = 1;
         end
      end else begin
         sz = bit_length(coef);
         while (zero_count > 15 && n < 3) begin
            burst[n]   = make_symbol(jbrs_pkg::SYM_ZRL, 1'b1, 12'd0, 0, r.component,
                                     at_end);
            n          = n + 1;
            zero_count = zero_count - 16;
         end
         burst[n] = make_symbol(8'(((zero_count & 15) << 4) + sz), 1'b1,
                                amplitude_code(coef, sz), sz, r.component, at_end);
         n          = n + 1;
         zero_count = 0;
      end
      for (k = 0; k < n; k++) begin
         if (k == n - 1) burst[k].last_of_item = 1'b1;
         expected_symbols.push_back(burst[k]);
      end
      if (at_end) begin
         coef_index = 0;
         zero_count = 0;
      end else begin
         coef_index = coef_index + 1;
      end
   endtask

   task automatic report_field(input string name, input int exp_val, input int got_val);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
   endtask

   task automatic queue_request(input int coef, input int prev, input int comp,
                                input bit drain);
      pending_request_type p;
      p.drain           = drain;
      p.req.coefficient = coef[jbrs_pkg::COEF_W-1:0];
      p.req.previous_dc = prev[jbrs_pkg::COEF_W-1:0];
      p.req.component   = comp[1:0];
      request_queue.push_back(p);
   endtask

   // queue the planned block; AC items carry random, unused previous_dc
   task automatic queue_plan(input int prev, input int comp, input bit drain);
      int i;
      queue_request(coef_plan[0], prev, comp, drain);
      for (i = 1; i < COEFFS_PER_BLOCK; i++)
         queue_request(coef_plan[i], int'($urandom_range(4095, 0)) - 2048, comp, 1'b0);
      for (i = 0; i < COEFFS_PER_BLOCK; i++) coef_plan[i] = 0;
   endtask

   function automatic int random_ac();
      int pick;
      int v;
      pick = $urandom_range(9, 0);
      if (pick < 2) begin
         case ($urandom_range(3, 0))
            0: v = -2048;
            1: v = 2047;
            2: v = -1;
            default: v = 1;
         endcase
      end else if (pick < 7) begin
         v = $urandom_range(31, 1);
         if ($urandom_range(1, 0)) v = -v;
      end else begin
         v = 0;
         while (v == 0) v = int'($urandom_range(4095, 0)) - 2048;
      end
      return v;
   endfunction

   // one well-formed block with random DC at the given zero density; rare stray component
   task automatic queue_random_block(input int zero_pct, input bit drain);
      int dc;
      int prev;
      int comp;
      int pick;
      int i;
      comp = $urandom_range(3, 0);
      pick = $urandom_range(9, 0);
      dc   = (pick < 2) ? 2047 : (pick < 4) ? -2048 : int'($urandom_range(4095, 0)) - 2048;
      pick = $urandom_range(9, 0);
      prev = (pick < 2) ? -2048 : (pick < 4) ? 2047 : (pick < 5) ? dc :
             int'($urandom_range(4095, 0)) - 2048;
      queue_request(dc, prev, comp, drain);
      for (i = 1; i < COEFFS_PER_BLOCK; i++)
         queue_request(($urandom_range(99, 0) < zero_pct) ? 0 : random_ac(),
                       int'($urandom_range(4095, 0)) - 2048,
                       ($urandom_range(99, 0) < 95) ? comp : int'($urandom_range(3, 0)),
                       1'b0);
   endtask

   // stimulus, end of run and verdict
   initial begin
      int zero_pct[4];
      int b;
      zero_pct = '{55, 85, 96, 100};
      for (b = 0; b < COEFFS_PER_BLOCK; b++) coef_plan[b] = 0;

      // largest DC difference, AC extremes, one run-sixteen, run of fifteen, dense tail
      coef_plan[0]  = 2047;
      coef_plan[1]  = -2048;
      coef_plan[2]  = 2047;
      coef_plan[3]  = 1;
      coef_plan[4]  = -1;
      coef_plan[21] = 5;
      coef_plan[37] = 100;
      for (b = 38; b < COEFFS_PER_BLOCK - 1; b++) coef_plan[b] = b - 50;
      queue_plan(-2048, 0, 1'b0);
      // zero DC difference, two run-sixteen, long trailing run gives only end of block
      coef_plan[0]  = -700;
      coef_plan[33] = -3;
      queue_plan(-700, 3, 1'b0);
      // most negative DC difference, 62 zeros then -2048 on the last position
      coef_plan[0]  = -2048;
      coef_plan[63] = -2048;
      queue_plan(2047, 2, 1'b0);
      // exactly 48 zeros: three run-sixteen with zero remainder
      coef_plan[0]  = 5;
      coef_plan[49] = 7;
      coef_plan[63] = -1;
      queue_plan(0, 1, 1'b0);

      for (b = 0; b < RANDOM_BLOCKS; b++) queue_random_block(zero_pct[b % 4], b == 0 || b == 2);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || req_valid) @(posedge clock);
      while (expected_symbols.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && expected_symbols.size() == 0) begin
         $display("jpeg_block_run_length_symbolizer_core regression: pass");
      end else begin
         $display("jpeg_block_run_length_symbolizer_core regression: fail");
      end
      $finish;
   end

   // request driver and result stall, both updated on the falling edge
   always @(negedge clock) begin
      calm = (requests_accepted >= CALM_FIRST && requests_accepted < CALM_LAST);
      if (!reset && (!req_valid || req_taken)) begin
         if (request_queue.size() != 0 && (calm || $urandom_range(99, 0) >= IDLE_PCT) &&
             !(request_queue[0].drain && expected_symbols.size() != 0)) begin
            head = request_queue.pop_front();
            req_payload <= head.req;
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !calm && ($urandom_range(99, 0) < IDLE_PCT);
   end

   // predict on each accepted request, then check each accepted result
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            symbolize_coefficient(req_payload);
            requests_accepted++;
         end
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (expected_symbols.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, expected none, got %0h", $time, rsp_payload);
            end else begin
               want = expected_symbols.pop_front();
               if (rsp_payload.symbol !== want.symbol)
                  report_field("symbol", want.symbol, rsp_payload.symbol);
               if (rsp_payload.is_ac !== want.is_ac)
                  report_field("is_ac", want.is_ac, rsp_payload.is_ac);
               if (rsp_payload.amplitude_bits !== want.amplitude_bits)
                  report_field("amplitude_bits", want.amplitude_bits,
                               rsp_payload.amplitude_bits);
               if (rsp_payload.amplitude_length !== want.amplitude_length)
                  report_field("amplitude_length", want.amplitude_length,
                               rsp_payload.amplitude_length);
               if (rsp_payload.component_out !== want.component_out)
                  report_field("component_out", want.component_out,
                               rsp_payload.component_out);
               if (rsp_payload.last_of_item !== want.last_of_item)
                  report_field("last_of_item", want.last_of_item, rsp_payload.last_of_item);
               if (rsp_payload.block_end !== want.block_end)
                  report_field("block_end", want.block_end, rsp_payload.block_end);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("jpeg_block_run_length_symbolizer_core regression: fail");
         $finish;
      end
   end

endmodule

// ----- sim.f -----
hdl/jbrs_pkg.sv
hdl/jbrs_front.sv
hdl/jbrs_queue.sv
hdl/jbrs_back.sv
hdl/jpeg_block_run_length_symbolizer_core.sv
hdl/jbrs_checker.sv
bench/jpeg_block_run_length_symbolizer_core_tb.sv
